[src/chunked_body_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define CHUNKED_BODY_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define CBD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CBD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[src/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Widths, byte codes, phase and status codes, decoder state type, hex lookup.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Widest chunk size the decoder accepts, in bits
  localparam int SIZE_BITS = 32;

  localparam logic [SIZE_BITS-1:0] SIZE_ZERO = '0;
  localparam logic [SIZE_BITS-1:0] SIZE_ONE  = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // Framing bytes
  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;

  // Decoder phases
  localparam logic [2:0] PH_SIZE  = 3'd0;  // collecting hex size digits
  localparam logic [2:0] PH_LF1   = 3'd1;  // LF that closes the size line
  localparam logic [2:0] PH_DATA  = 3'd2;  // payload bytes
  localparam logic [2:0] PH_CR    = 3'd3;  // CR after the payload
  localparam logic [2:0] PH_LF2   = 3'd4;  // LF after the payload
  localparam logic [2:0] PH_ERROR = 3'd5;  // sticky framing error

  // Result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  typedef struct packed {
    logic [2:0]           phase;
    logic [SIZE_BITS-1:0] size_accum;
    logic                 digit_seen;
    logic [SIZE_BITS-1:0] remaining;   // payload bytes still due
    logic                 zero_chunk;  // current chunk has size zero
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic [1:0] status;
  } result_t;

  // Hex digit lookup: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

[src/cbd_ifs.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready channels for raw body bytes and decoded results.
// ----------------------------------------------------------------------------
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink   (input valid, input body_byte, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;

  modport source (output valid, output data_byte, output status, input ready);
  modport sink   (input valid, input data_byte, input status, output ready);
endinterface

[src/cbd_step.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder step logic
// Next state and optional result for one body byte.
// ----------------------------------------------------------------------------
module cbd_step (
  input  cbd_pkg::state_t  st,
  input  logic [7:0]       body_byte,
  output cbd_pkg::state_t  st_next,
  output cbd_pkg::result_t res
);
  import cbd_pkg::*;

  logic [4:0] hv;
  logic       fail;

  assign hv = hex_value(body_byte);

  always_comb begin
    st_next = st;
    fail    = 1'b0;
    res     = '0;
    case (st.phase)
      PH_SIZE: begin
        if (body_byte == BYTE_CR) begin
          if (!st.digit_seen) begin
            fail = 1'b1;
          end else begin
            st_next.remaining  = st.size_accum;
            st_next.zero_chunk = (st.size_accum == SIZE_ZERO);
            st_next.size_accum = SIZE_ZERO;
            st_next.digit_seen = 1'b0;
            st_next.phase      = PH_LF1;
          end
        end else if (!hv[4] || st.size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
          // non-hex byte, or one more digit would overflow
          fail = 1'b1;
        end else begin
          st_next.size_accum = {st.size_accum[SIZE_BITS-5:0], hv[3:0]};
          st_next.digit_seen = 1'b1;
        end
      end
      PH_LF1: begin
        if (body_byte != BYTE_LF) begin
          fail = 1'b1;
        end else begin
          st_next.phase = st.zero_chunk ? PH_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        res.valid         = 1'b1;
        res.data_byte     = body_byte;
        res.status        = ST_DATA;
        st_next.remaining = st.remaining - SIZE_ONE;
        if (st.remaining == SIZE_ONE) begin
          st_next.phase = PH_CR;
        end
      end
      PH_CR: begin
        if (body_byte != BYTE_CR) begin
          fail = 1'b1;
        end else begin
          st_next.phase = PH_LF2;
        end
      end
      PH_LF2: begin
        if (body_byte != BYTE_LF) begin
          fail = 1'b1;
        end else begin
          st_next.phase = PH_SIZE;
          if (st.zero_chunk) begin
            res.valid  = 1'b1;
            res.status = ST_DONE;
          end
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase

    // framing fault: sticky error, one error result per byte
    if (fail) begin
      st_next.phase = PH_ERROR;
      res.valid     = 1'b1;
      res.data_byte = 8'd0;
      res.status    = ST_ERROR;
    end
  end

endmodule

[src/chunked_body_decoder_core.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder core
// Decodes a chunked transfer body one byte per cycle. Each byte is taken
// into an input register and from there passes through the step logic
// (hex size shift, payload count down, framing checks) into the decoder
// state and the result register, so a byte is accepted every cycle while
// the result side takes results. Payload bytes come out with status 0, the
// LF that ends a zero-size chunk gives status 2, and any framing or size
// fault gives status 1 for that byte and every byte after it until reset.
// Size digits and framing bytes give no result.
// ----------------------------------------------------------------------------
module chunked_body_decoder_core (
  input logic              clk,
  input logic              rst,
  cbd_in_if.sink           body_in,
  cbd_out_if.source        data_out
);
  import cbd_pkg::*;
  `include "chunked_body_decoder_core_macros.svh"

  state_t     st;
  state_t     st_next;
  result_t    res;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       out_valid;
  logic [7:0] out_data;
  logic [1:0] out_status;

  // Handshake: result register free when empty or being taken
  assign out_free      = !out_valid || data_out.ready;
  assign body_in.ready = !s1_valid || out_free;

  assign data_out.valid     = out_valid;
  assign data_out.data_byte = out_data;
  assign data_out.status    = out_status;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (body_in.ready) begin
      s1_valid <= body_in.valid;
    end
    if (body_in.ready && body_in.valid) begin
      s1_byte <= body_in.body_byte;
    end
  end

  cbd_step u_step (
    .st        (st),
    .body_byte (s1_byte),
    .st_next   (st_next),
    .res       (res)
  );

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_SIZE, size_accum: SIZE_ZERO, digit_seen: 1'b0,
              remaining: SIZE_ZERO, zero_chunk: 1'b0};
    end else if (s1_valid && out_free) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && res.valid;
    end
    if (out_free && s1_valid && res.valid) begin
      out_data   <= res.data_byte;
      out_status <= res.status;
    end
  end

  // Checks
  `CBD_ASSERT_NEXT(a_error_sticky, clk, rst, st.phase == PH_ERROR,
    st.phase == PH_ERROR, "error phase left before reset")
  `CBD_ASSERT_IMPL(a_data_count, clk, rst, st.phase == PH_DATA,
    st.remaining != SIZE_ZERO, "payload phase with no bytes due")
  `CBD_ASSERT_NEXT(a_data_only_in_body, clk, rst,
    s1_valid && out_free && st.phase != PH_DATA,
    !(data_out.valid && data_out.status == ST_DATA),
    "payload result outside payload phase")
  `CBD_ASSERT_IMPL(a_status_code, clk, rst, out_valid,
    out_status == ST_DATA || out_status == ST_ERROR || out_status == ST_DONE,
    "undefined result status")
  `CBD_ASSERT_IMPL(a_input_free, clk, rst, !s1_valid, body_in.ready,
    "input stalled with empty input register")

endmodule

[bench/cbd_result_checker.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder result checker
// Watches the body byte and result channels, decodes each accepted byte
// with its own model of the framing rules, and compares every accepted
// result against the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbd_result_checker (
  input  logic        clk,
  input  logic        rst,
  cbd_in_if           body_mon,
  cbd_out_if          result_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import cbd_pkg::*;

  localparam int LEFT_BITS = SIZE_BITS + 2;
  localparam logic [LEFT_BITS-1:0] FRAME_BYTES = LEFT_BITS'(3);

  typedef enum logic [1:0] {
    SCAN_SIZE,
    SCAN_BODY,
    SCAN_FAULT
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
  } decoded_t;

  scan_phase_e          scan;
  logic [SIZE_BITS-1:0] size_acc;
  logic                 have_digit;
  logic [LEFT_BITS-1:0] left;
  logic [SIZE_BITS-1:0] chunk_len;

  decoded_t    decoded_q[$];
  int unsigned err_count;

  // Hex digit test; nib holds the digit value when it is one
  function automatic bit is_hex(input logic [7:0] b, output logic [3:0] nib);
    nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = b[3:0];
      return 1'b1;
    end
    if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      nib = 4'(b[2:0] + 3'd1) + 4'd8;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Decode one body byte, update the framing state, give the result if any
  task automatic decode_byte(input logic [7:0] b, output bit emits, output decoded_t res);
    logic [3:0] nib;
    bit         bad;
    emits = 1'b0;
    res   = '0;
    bad   = 1'b0;
    case (scan)
      SCAN_SIZE: begin
        if (b == BYTE_CR) begin
          if (!have_digit) begin
            bad = 1'b1;
          end else begin
            chunk_len  = size_acc;
            left       = {2'b00, size_acc} + FRAME_BYTES;
            size_acc   = '0;
            have_digit = 1'b0;
            scan       = SCAN_BODY;
          end
        end else if (!is_hex(b, nib)) begin
          bad = 1'b1;
        end else if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
          // next shift would drop set bits
          bad = 1'b1;
        end else begin
          size_acc   = {size_acc[SIZE_BITS-5:0], nib};
          have_digit = 1'b1;
        end
      end
      SCAN_BODY: begin
        if (left == {2'b00, chunk_len} + FRAME_BYTES) begin
          if (b != BYTE_LF) bad = 1'b1;
          else left = left - 1'b1;
        end else if (left == LEFT_BITS'(2)) begin
          if (b != BYTE_CR) bad = 1'b1;
          else left = left - 1'b1;
        end else if (left == LEFT_BITS'(1)) begin
          if (b != BYTE_LF) begin
            bad = 1'b1;
          end else begin
            left = '0;
            scan = SCAN_SIZE;
            if (chunk_len == '0) begin
              emits      = 1'b1;
              res.status = ST_DONE;
            end
          end
        end else if (left == '0) begin
          bad = 1'b1;
        end else begin
          left          = left - 1'b1;
          emits         = 1'b1;
          res.data_byte = b;
          res.status    = ST_DATA;
        end
      end
      default: bad = 1'b1;
    endcase
    // sticky fault: every byte from here on reports an error
    if (bad) begin
      scan          = SCAN_FAULT;
      emits         = 1'b1;
      res.data_byte = 8'h00;
      res.status    = ST_ERROR;
    end
  endtask

  // Decode accepted bytes, then match accepted results in order
  always @(posedge clk) begin
    bit       emits;
    decoded_t res;
    decoded_t want;
    if (rst) begin
      scan        = SCAN_SIZE;
      size_acc    = '0;
      have_digit  = 1'b0;
      left        = '0;
      chunk_len   = '0;
      err_count   = 0;
      decoded_q.delete();
    end else begin
      if (body_mon.valid && body_mon.ready) begin
        decode_byte(body_mon.body_byte, emits, res);
        if (emits) decoded_q.push_back(res);
      end
      if (result_mon.valid && result_mon.ready) begin
        if (decoded_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual data %02h status %0d",
                   $time, result_mon.data_byte, result_mon.status);
        end else begin
          want = decoded_q.pop_front();
          if (result_mon.data_byte !== want.data_byte) begin
            err_count++;
            $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                     $time, want.data_byte, result_mon.data_byte);
          end
          if (result_mon.status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, result_mon.status);
          end
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= decoded_q.size();
  end

endmodule

[bench/tb_chunked_body_decoder_core.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds well-formed chunked bodies with random sizes, digit case, leading
// zeros and payload under random source gaps and sink stalls, then ends
// with one randomly chosen framing or size fault and trailing bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chunked_body_decoder_core;
  import cbd_pkg::*;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // Fault kinds for the closing part of the run
  typedef enum int {
    FAULT_EMPTY_LINE,
    FAULT_NON_HEX,
    FAULT_TOO_WIDE,
    FAULT_NO_LF_AFTER_SIZE,
    FAULT_NO_CR_AFTER_DATA,
    FAULT_NO_LF_AFTER_DATA
  } fault_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbd_in_if  body_ch();
  cbd_out_if result_ch();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int unsigned stall_left = 0;

  chunked_body_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .body_in  (body_ch),
    .data_out (result_ch)
  );

  cbd_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .body_mon    (body_ch),
    .result_mon  (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CH_ZERO + 8'(nib);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
  endfunction

  // Result side: random stalls, with steady stretches
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // One transaction on the body channel, after an optional idle gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      body_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    body_ch.valid     <= 1'b1;
    body_ch.body_byte <= b;
    do @(posedge clk); while (!body_ch.ready);
    bytes_sent++;
  endtask

  // Hold the source off until every decoded result has come out
  task automatic drain_results();
    body_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Size line, framing and random payload; case_mode 0 lower, 1 upper, 2 mixed
  task automatic send_chunk(input int unsigned len, input int unsigned lead,
                            input int unsigned case_mode);
    logic [7:0]  digits[$];
    int unsigned v;
    bit          upper;
    v = len;
    do begin
      upper = (case_mode == 2) ? bit'($urandom_range(0, 1)) : bit'(case_mode);
      digits.push_front(hex_char(v[3:0], upper));
      v = v >> 4;
    end while (v != 0);
    repeat (lead) send_byte(CH_ZERO);
    foreach (digits[i]) send_byte(digits[i]);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  // Closing fault: leaves the decoder in its sticky error state
  task automatic send_fault(input fault_kind_e kind);
    logic [7:0] b;
    case (kind)
      FAULT_EMPTY_LINE: begin
        send_byte(BYTE_CR);
      end
      FAULT_NON_HEX: begin
        if ($urandom_range(0, 1) == 1) send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        do begin
          b = 8'($urandom_range(0, 255));
        end while ((b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOWER_A && b <= CH_LOWER_F) ||
                   (b >= CH_UPPER_A && b <= CH_UPPER_F) || b == BYTE_CR);
        send_byte(b);
      end
      FAULT_TOO_WIDE: begin
        // leading zeros, a nonzero digit, then eight more digits
        repeat ($urandom_range(0, 2)) send_byte(CH_ZERO);
        send_byte(hex_char(4'($urandom_range(1, 15)), bit'($urandom_range(0, 1))));
        repeat (8) send_byte(hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1))));
      end
      FAULT_NO_LF_AFTER_SIZE: begin
        send_byte(hex_char(4'd5, 1'b0));
        send_byte(BYTE_CR);
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF);
        send_byte(b);
      end
      FAULT_NO_CR_AFTER_DATA: begin
        send_byte(hex_char(4'd3, 1'b0));
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR);
        send_byte(b);
      end
      default: begin
        send_byte(hex_char(4'd3, 1'b0));
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        send_byte(BYTE_CR);
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF);
        send_byte(b);
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned lead;
    body_ch.valid     = 1'b0;
    body_ch.body_byte = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero-size chunk, leading zeros with payload extremes, one mid byte
    send_chunk(0, 0, 0);
    repeat (4) send_byte(CH_ZERO);
    send_byte(hex_char(4'd2, 1'b0));
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(hex_char(4'd1, 1'b0));
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(8'h80);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    drain_results();

    // Random well-formed chunks
    while (bytes_sent < 820) begin
      r = $urandom_range(0, 99);
      if (r < 15) len = 0;
      else if (r < 70) len = $urandom_range(1, 15);
      else if (r < 95) len = $urandom_range(16, 63);
      else len = $urandom_range(64, 300);
      lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      send_chunk(len, lead, $urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) src_steady = !src_steady;
      if ($urandom_range(0, 15) == 0) sink_steady <= !sink_steady;
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    // One fault, then bytes that must all report the error
    src_steady = 1'b0;
    send_fault(fault_kind_e'($urandom_range(0, 5)));
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    body_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("chunked_body_decoder_core verification clean");
    end else begin
      $display("chunked_body_decoder_core verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("chunked_body_decoder_core verification failed");
    $finish;
  end

endmodule
